@@ hw/rtl/ppm_pkg.sv @@
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types and constants for the per-pixel median block.
// ----------------------------------------------------------------------------
package ppm_pkg;

   localparam int SAMPLE_W         = 8;
   localparam int COUNT_W          = 5;
   localparam int PIX_W            = 23;
   localparam int PIX_CNT_W        = 22;
   localparam int CSR_W            = 23;
   localparam int MAX_SAMPLES_DEF  = 16;
   localparam int FRAME_PIXELS_MAX = 4194304;

   typedef enum logic [0:0] {
      CSR_SAMPLE_COUNT = 1'b0,
      CSR_FRAME_PIXELS = 1'b1
   } csr_index_type;

   // what one cell hands to its right neighbor
   typedef struct packed {
      logic                gt;
      logic [SAMPLE_W-1:0] value;
   } link_type;

endpackage

@@ hw/rtl/per_pixel_median_baseline.sv @@
// ----------------------------------------------------------------------------
// per_pixel_median_baseline
// Temporal median per pixel: sorts each pixel's samples in an insertion
// chain and emits the upper-middle element, flagging the frame's last pixel.
// ----------------------------------------------------------------------------
//  channel  dir  handshake         payload
//  req_     in   tvalid / tready   tdata[7:0] = sample
//  rsp_     out  tvalid / tready   tdata[7:0] = median, tlast = frame_done
//  csr_     in   we                index 0 sample_count, 1 frame_pixels
//
//  One item per cycle; every sample is placed in the chain in the cycle
//  it is accepted, and the median lands in the output register at that edge.
//  req_tready drops only for a pixel-ending item while the output register
//  is full and not being taken.
//  Synchronous reset clears counters and the output valid; the sample
//  cells are not reset.
// ----------------------------------------------------------------------------
module per_pixel_median_baseline #(
   parameter int MAX_SAMPLES = ppm_pkg::MAX_SAMPLES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] sample
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [7:0] median
   output logic                         rsp_tlast,
   input  logic                         csr_we,
   input  logic [0:0]                   csr_index,
   input  logic [ppm_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CMP_W = (CNT_W > ppm_pkg::COUNT_W) ? CNT_W : ppm_pkg::COUNT_W;

   logic [ppm_pkg::COUNT_W-1:0]   sample_count_ff;
   logic [ppm_pkg::PIX_W-1:0]     frame_pixels_ff;
   logic [CNT_W-1:0]              taken_ff;
   logic [CNT_W-1:0]              taken_in;
   logic [ppm_pkg::PIX_CNT_W-1:0] pixels_ff;
   logic [ppm_pkg::PIX_CNT_W-1:0] pixels_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [ppm_pkg::SAMPLE_W-1:0]  median_ff;
   logic                          done_ff;

   logic [CNT_W-1:0]              count_new;
   logic [CNT_W-1:0]              mid;
   logic [CMP_W-1:0]              eff_samples;
   logic [ppm_pkg::PIX_W-1:0]     eff_pixels;
   logic [ppm_pkg::PIX_W-1:0]     pix_new;
   logic                          pixel_end;
   logic                          frame_end;
   logic                          accept;
   logic [ppm_pkg::SAMPLE_W-1:0]  median;

   always_comb begin
      count_new = taken_ff + CNT_W'(1);
      mid       = count_new >> 1;
      if (sample_count_ff == '0) begin
         eff_samples = CMP_W'(1);
      end else if (CMP_W'(sample_count_ff) > CMP_W'(MAX_SAMPLES)) begin
         eff_samples = CMP_W'(MAX_SAMPLES);
      end else begin
         eff_samples = CMP_W'(sample_count_ff);
      end
      pixel_end = CMP_W'(count_new) >= eff_samples;

      if (frame_pixels_ff == '0) begin
         eff_pixels = ppm_pkg::PIX_W'(1);
      end else if (frame_pixels_ff > ppm_pkg::PIX_W'(ppm_pkg::FRAME_PIXELS_MAX)) begin
         eff_pixels = ppm_pkg::PIX_W'(ppm_pkg::FRAME_PIXELS_MAX);
      end else begin
         eff_pixels = frame_pixels_ff;
      end
      pix_new   = {1'b0, pixels_ff} + ppm_pkg::PIX_W'(1);
      frame_end = pix_new >= eff_pixels;

      req_tready = !pixel_end || !rsp_valid_ff || rsp_tready;
      accept     = req_tvalid && req_tready;

      taken_in     = taken_ff;
      pixels_in    = pixels_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         if (pixel_end) begin
            taken_in     = '0;
            pixels_in    = frame_end ? '0 : pix_new[ppm_pkg::PIX_CNT_W-1:0];
            rsp_valid_in = 1'b1;
         end else begin
            taken_in = count_new;
         end
      end
   end

   ppm_chain #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W)
   ) u_chain (
      .clock  (clock),
      .insert (accept),
      .sample (req_tdata),
      .taken  (taken_ff),
      .mid    (mid),
      .median (median)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= ppm_pkg::COUNT_W'(1);
         frame_pixels_ff <= ppm_pkg::PIX_W'(1);
         taken_ff        <= '0;
         pixels_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         taken_ff     <= taken_in;
         pixels_ff    <= pixels_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (ppm_pkg::csr_index_type'(csr_index))
               ppm_pkg::CSR_SAMPLE_COUNT: begin
                  sample_count_ff <= csr_wdata[ppm_pkg::COUNT_W-1:0];
               end
               ppm_pkg::CSR_FRAME_PIXELS: begin
                  frame_pixels_ff <= csr_wdata[ppm_pkg::PIX_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pixel_end) begin
         median_ff <= median;
         done_ff   <= frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = median_ff;
   assign rsp_tlast  = done_ff;

   a_taken_range: assert property (@(posedge clock) disable iff (reset)
      taken_ff < CNT_W'(MAX_SAMPLES))
      else $error("sample count reached chain depth");

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && pixel_end |=> rsp_valid_ff && taken_ff == '0)
      else $error("pixel end without result or count clear");

   a_taken_step: assert property (@(posedge clock) disable iff (reset)
      accept && !pixel_end |=> taken_ff == $past(count_new))
      else $error("sample count did not advance");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !(accept && pixel_end) || rsp_tready)
      else $error("result overwritten while waiting");

endmodule

@@ hw/rtl/ppm_cell.sv @@
// ----------------------------------------------------------------------------
// ppm_cell
// One slot of the insertion chain: holds one sorted sample and shifts in
// its left neighbor's value when the new sample sorts below it.
// ----------------------------------------------------------------------------
module ppm_cell (
   input  logic                         clock,
   input  logic                         insert,
   input  logic                         occupied,
   input  logic [ppm_pkg::SAMPLE_W-1:0] sample,
   input  ppm_pkg::link_type            left,
   output ppm_pkg::link_type            right,
   output logic [ppm_pkg::SAMPLE_W-1:0] value_next
);

   logic [ppm_pkg::SAMPLE_W-1:0] value_ff;
   logic [ppm_pkg::SAMPLE_W-1:0] value_in;
   logic                         gt;

   always_comb begin
      gt = occupied && (value_ff > sample);
      if (left.gt) begin
         value_in = left.value;
      end else if (gt || !occupied) begin
         value_in = sample;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         value_ff <= value_in;
      end
   end

   assign right.gt    = gt;
   assign right.value = value_ff;
   assign value_next  = value_in;

endmodule

@@ hw/rtl/ppm_chain.sv @@
// ----------------------------------------------------------------------------
// ppm_chain
// Row of sort cells; inserts one sample per cycle while insert is high and
// picks the element at the middle index of the updated row.
// ----------------------------------------------------------------------------
module ppm_chain #(
   parameter int MAX_SAMPLES = ppm_pkg::MAX_SAMPLES_DEF,
   parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
   parameter int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
   input  logic                         clock,
   input  logic                         insert,
   input  logic [ppm_pkg::SAMPLE_W-1:0] sample,
   input  logic [CNT_W-1:0]             taken,
   input  logic [CNT_W-1:0]             mid,
   output logic [ppm_pkg::SAMPLE_W-1:0] median
);

   ppm_pkg::link_type            link [MAX_SAMPLES+1];
   logic [ppm_pkg::SAMPLE_W-1:0] value_next [MAX_SAMPLES];

   assign link[0].gt    = 1'b0;
   assign link[0].value = '0;

   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      ppm_cell u_cell (
         .clock      (clock),
         .insert     (insert),
         .occupied   (taken > CNT_W'(i)),
         .sample     (sample),
         .left       (link[i]),
         .right      (link[i+1]),
         .value_next (value_next[i])
      );
   end

   assign median = value_next[mid[IDX_W-1:0]];

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for per_pixel_median_baseline. A short table of directed items
// (field extremes, zero and saturated register values, even and odd counts,
// a count lowered mid-pixel) is followed by random phases. Each phase writes
// new register values while idle, then streams samples. Each result is checked
// against its table value or an in-bench model of the sorted store and counters.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASES         = 12;
   localparam int DIR_N          = 28;

   typedef struct packed {
      logic [7:0] median;
      logic       frame_done;
   } pixel_result_type;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      ppm_pkg::csr_index_type index;
      logic [22:0]            data;
      logic                   typed;
      logic [7:0]             median;
      logic                   last;
   } row_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_we     = 1'b0;
   logic [0:0]                csr_index  = '0;
   logic [ppm_pkg::CSR_W-1:0] csr_wdata  = '0;

   // model state
   logic [4:0]        cfg_samples;
   logic [22:0]       cfg_pixels;
   logic [7:0]        sorted_store [ppm_pkg::MAX_SAMPLES_DEF];
   int                held_count;
   int                pixel_count;

   pixel_result_type  median_q [$];
   int                error_count   = 0;
   int                quiet_cycles  = 0;
   int                req_gap_pct   = 0;
   int                rsp_stall_pct = 0;

   row_type dir_rows [DIR_N] = '{
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd0,       1'b1, 8'h00, 1'b1},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd255,     1'b1, 8'hFF, 1'b1},
      '{ROW_CSR,    ppm_pkg::CSR_SAMPLE_COUNT, 23'd0,       1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'hA5,      1'b1, 8'hA5, 1'b1},
      '{ROW_CSR,    ppm_pkg::CSR_FRAME_PIXELS, 23'd0,       1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'h5A,      1'b1, 8'h5A, 1'b1},
      '{ROW_CSR,    ppm_pkg::CSR_SAMPLE_COUNT, 23'd3,       1'b0, 8'h00, 1'b0},
      '{ROW_CSR,    ppm_pkg::CSR_FRAME_PIXELS, 23'd2,       1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd200,     1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd10,      1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd100,     1'b1, 8'd100, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd255,     1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd0,       1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd128,     1'b1, 8'd128, 1'b1},
      '{ROW_CSR,    ppm_pkg::CSR_SAMPLE_COUNT, 23'd2,       1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd7,       1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd9,       1'b1, 8'd9,  1'b0},
      '{ROW_CSR,    ppm_pkg::CSR_SAMPLE_COUNT, 23'd5,       1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd3,       1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd2,       1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd1,       1'b0, 8'h00, 1'b0},
      '{ROW_CSR,    ppm_pkg::CSR_SAMPLE_COUNT, 23'd2,       1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'd0,       1'b0, 8'h00, 1'b0},
      '{ROW_CSR,    ppm_pkg::CSR_SAMPLE_COUNT, 23'd1,       1'b0, 8'h00, 1'b0},
      '{ROW_CSR,    ppm_pkg::CSR_FRAME_PIXELS, 23'd4194304, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'h80,      1'b1, 8'h80, 1'b0},
      '{ROW_CSR,    ppm_pkg::CSR_FRAME_PIXELS, 23'h7FFFFF,  1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, ppm_pkg::CSR_SAMPLE_COUNT, 23'h01,      1'b0, 8'h00, 1'b0}
   };

   per_pixel_median_baseline DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] median
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // insert into the sorted store; a pixel ends once the effective count is held
   task automatic predict_median(input logic [7:0] v, output bit has_res,
                                 output pixel_result_type res);
      int pos;
      int mid;
      int eff_n;
      int eff_p;
      eff_n = (cfg_samples == 0) ? 1 :
              (cfg_samples > ppm_pkg::MAX_SAMPLES_DEF) ? ppm_pkg::MAX_SAMPLES_DEF :
              int'(cfg_samples);
      eff_p = (cfg_pixels == 0) ? 1 :
              (cfg_pixels > ppm_pkg::FRAME_PIXELS_MAX) ? ppm_pkg::FRAME_PIXELS_MAX :
              int'(cfg_pixels);
      has_res = 1'b0;
      res     = '0;
      pos     = held_count;
      if (pos < ppm_pkg::MAX_SAMPLES_DEF) begin
         while (pos > 0 && sorted_store[pos-1] > v) begin
            sorted_store[pos] = sorted_store[pos-1];
            pos--;
         end
         sorted_store[pos] = v;
         held_count++;
      end
      if (held_count >= eff_n) begin
         mid = held_count / 2;
         if (mid >= ppm_pkg::MAX_SAMPLES_DEF) mid = ppm_pkg::MAX_SAMPLES_DEF - 1;
         res.median = sorted_store[mid];
         held_count = 0;
         pixel_count++;
         if (pixel_count >= eff_p) begin
            res.frame_done = 1'b1;
            pixel_count    = 0;
         end
         has_res = 1'b1;
      end
   endtask

   task automatic feed_sample(input logic [7:0] v, input bit typed,
                              input pixel_result_type typed_res);
      bit               has_res;
      pixel_result_type res;
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      predict_median(v, has_res, res);
      if (typed) median_q.push_back(typed_res);
      else if (has_res) median_q.push_back(res);
   endtask

   // registers change only with no item in flight
   task automatic write_reg(input ppm_pkg::csr_index_type idx, input logic [22:0] data);
      req_tvalid <= 1'b0;
      while (median_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == ppm_pkg::CSR_SAMPLE_COUNT) cfg_samples = data[4:0];
      else cfg_pixels = data;
   endtask

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (median_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected item median=%h last=%b", $time,
                        rsp_tdata, rsp_tlast);
            end else begin
               want = median_q.pop_front();
               if (rsp_tdata !== want.median) begin
                  error_count++;
                  $display("%0t: median expected %h actual %h", $time,
                           want.median, rsp_tdata);
               end
               if (rsp_tlast !== want.frame_done) begin
                  error_count++;
                  $display("%0t: frame_done expected %b actual %b", $time,
                           want.frame_done, rsp_tlast);
               end
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int               k;
      int               phase;
      int               n;
      int               style;
      int               lo;
      int               pick;
      logic [4:0]       sc;
      logic [22:0]      fp;
      logic [22:0]      wd;
      logic [7:0]       v;
      pixel_result_type typed_res;

      cfg_samples = 5'd1;
      cfg_pixels  = 23'd1;
      held_count  = 0;
      pixel_count = 0;
      req_gap_pct   = 15;
      rsp_stall_pct = 64;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIR_N; k++) begin
         if (dir_rows[k].kind == ROW_CSR) begin
            write_reg(dir_rows[k].index, dir_rows[k].data);
         end else begin
            typed_res.median     = dir_rows[k].median;
            typed_res.frame_done = dir_rows[k].last;
            feed_sample(dir_rows[k].data[7:0], dir_rows[k].typed, typed_res);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase < 4) begin
            req_gap_pct   = 15;
            rsp_stall_pct = 64;
         end else if (phase < 8) begin
            req_gap_pct   = 64;
            rsp_stall_pct = 15;
         end else begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end

         pick = $urandom_range(9);
         if (phase == 1) sc = 5'd31;
         else if (phase == 2) sc = 5'd16;
         else if (pick == 0) sc = 5'd0;
         else if (pick == 1) sc = 5'd17 + 5'($urandom_range(14));
         else if (pick == 2) sc = 5'($urandom_range(8, 16));
         else sc = 5'($urandom_range(1, 6));
         // upper bits of the count write are don't-care
         wd = (phase % 2) ? ((23'($urandom) & 23'h7FFFE0) | 23'(sc)) : 23'(sc);
         write_reg(ppm_pkg::CSR_SAMPLE_COUNT, wd);

         pick = $urandom_range(9);
         if (phase == 3) fp = 23'($urandom);
         else if (pick == 0) fp = 23'd0;
         else if (pick == 1) fp = 23'($urandom);
         else fp = 23'($urandom_range(1, 6));
         if (phase < 4 || $urandom_range(1)) write_reg(ppm_pkg::CSR_FRAME_PIXELS, fp);

         style = $urandom_range(2);
         n     = $urandom_range(50, 100);
         for (k = 0; k < n; k++) begin
            lo = $urandom_range(252);
            if (style == 0) v = 8'($urandom);
            else if (style == 1) v = 8'($urandom_range(lo, lo + 3));
            else v = $urandom_range(1) ? 8'hFF : ($urandom_range(1) ? 8'h00 : 8'($urandom));
            feed_sample(v, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (median_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && median_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/ppm_pkg.sv
hw/rtl/ppm_cell.sv
hw/rtl/ppm_chain.sv
hw/rtl/per_pixel_median_baseline.sv
test/tb_top.sv
